>>> design/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types, codes and helpers for the blocked fp32 matrix multiply core.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int TILE        = 4;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_IDX_W     = 1;
    localparam int Q_CNT_W     = 2;
    localparam int FMA_STAGES  = 6;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [1:0] ACT_WR_A = 2'd0;
    localparam logic [1:0] ACT_WR_B = 2'd1;
    localparam logic [1:0] ACT_TILE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd2;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] PINF = 32'h7F80_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  out_row;
        logic [5:0]  out_col;
        logic [31:0] out_value;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        K_WR_A = 2'd0,
        K_WR_B = 2'd1,
        K_TILE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } t_cmd;

    // position of the highest set bit, 0 for zero
    function automatic logic [5:0] top_bit(input logic [63:0] v);
        logic [5:0] tb;
        tb = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) tb = 6'(i);
        end
        return tb;
    endfunction

endpackage

>>> design/bmm_front.sv
// ----------------------------------------------------------------------------
// bmm_front
// Takes items and config writes, sorts items into commands, queues them.
// ----------------------------------------------------------------------------
module bmm_front #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bmm_pkg::t_in_item             i_item,
    input  logic                          i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bmm_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_pop,
    output logic                          o_cmd_valid,
    output bmm_pkg::t_cmd                 o_cmd,
    output logic [bmm_pkg::CFG_W-1:0]     o_k
);

    localparam int TOP = (MAX_DIM / 4) * 4;

    logic [bmm_pkg::CFG_W-1:0] r_row_count, r_col_count, r_inner_size;
    bmm_pkg::t_cmd             r_q [bmm_pkg::Q_DEPTH];
    logic [bmm_pkg::Q_IDX_W-1:0] r_wp, r_rp;
    logic [bmm_pkg::Q_CNT_W-1:0] r_cnt, n_cnt;

    logic                      w_push, w_keep, w_in_store;
    bmm_pkg::t_cmd             w_cmd;
    logic [bmm_pkg::CFG_W-1:0] w_n, w_m;

    function automatic logic [bmm_pkg::CFG_W-1:0] eff_size(input logic [bmm_pkg::CFG_W-1:0] raw);
        logic [bmm_pkg::CFG_W-1:0] v;
        v = raw & 7'h7C;
        if (v < 7'd4) v = 7'd4;
        if (32'(v) > TOP) v = bmm_pkg::CFG_W'(TOP);
        return v;
    endfunction

    assign w_n = eff_size(r_row_count);
    assign w_m = eff_size(r_col_count);
    assign o_k = eff_size(r_inner_size);

    assign w_in_store = (32'(i_item.row) < 32'(MAX_DIM)) && (32'(i_item.col) < 32'(MAX_DIM));

    always_comb begin
        w_cmd.kind  = bmm_pkg::K_TILE;
        w_cmd.row   = i_item.row;
        w_cmd.col   = i_item.col;
        w_cmd.value = i_item.value;
        w_keep      = 1'b0;
        unique case (i_item.action)
            bmm_pkg::ACT_WR_A: begin
                w_cmd.kind = bmm_pkg::K_WR_A;
                w_keep     = w_in_store;
            end
            bmm_pkg::ACT_WR_B: begin
                w_cmd.kind = bmm_pkg::K_WR_B;
                w_keep     = w_in_store;
            end
            bmm_pkg::ACT_TILE: begin
                w_cmd.row = {i_item.row[5:2], 2'b00};
                w_cmd.col = {i_item.col[5:2], 2'b00};
                w_keep    = ({1'b0, w_cmd.row} < w_n) && ({1'b0, w_cmd.col} < w_m);
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign busy   = (r_cnt == bmm_pkg::Q_CNT_W'(bmm_pkg::Q_DEPTH));
    assign w_push = start && !busy && w_keep;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_pop) n_cnt = r_cnt + 1'b1;
        else if (!w_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= bmm_pkg::SIZE_RESET;
            r_col_count  <= bmm_pkg::SIZE_RESET;
            r_inner_size <= bmm_pkg::SIZE_RESET;
            r_wp         <= '0;
            r_rp         <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bmm_pkg::REG_ROW_COUNT:  r_row_count  <= i_cfg_wdata;
                    bmm_pkg::REG_COL_COUNT:  r_col_count  <= i_cfg_wdata;
                    bmm_pkg::REG_INNER_SIZE: r_inner_size <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

endmodule

>>> design/bmm_fma.sv
// ----------------------------------------------------------------------------
// bmm_fma
// Six-stage fp32 fused multiply-add a*b+c, one rounding, nearest even.
// ----------------------------------------------------------------------------
module bmm_fma (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic        o_done,
    output logic [31:0] o_result
);

    logic [bmm_pkg::FMA_STAGES-1:0] r_v;

    // stage 1: classify, multiply
    logic        w_sa, w_sb, w_sc, w_sp;
    logic [7:0]  w_ea, w_eb, w_ec;
    logic [22:0] w_fa, w_fb, w_fc;
    logic        w_ainf, w_binf, w_cinf, w_azero, w_bzero, w_czero;
    logic        w_spec;
    logic [31:0] w_sval;

    logic [47:0] r1_prod;
    logic [8:0]  r1_eab;
    logic [23:0] r1_cm;
    logic [7:0]  r1_ce;
    logic        r1_sp, r1_sc, r1_czero, r1_spec;
    logic [31:0] r1_sval;

    assign w_sa = i_a[31];
    assign w_sb = i_b[31];
    assign w_sc = i_c[31];
    assign w_sp = w_sa ^ w_sb;
    assign w_ea = i_a[30:23];
    assign w_eb = i_b[30:23];
    assign w_ec = i_c[30:23];
    assign w_fa = i_a[22:0];
    assign w_fb = i_b[22:0];
    assign w_fc = i_c[22:0];
    assign w_ainf  = (w_ea == 8'hFF);
    assign w_binf  = (w_eb == 8'hFF);
    assign w_cinf  = (w_ec == 8'hFF);
    assign w_azero = (w_ea == 8'h00) && (w_fa == '0);
    assign w_bzero = (w_eb == 8'h00) && (w_fb == '0);
    assign w_czero = (w_ec == 8'h00) && (w_fc == '0);

    always_comb begin
        w_spec = 1'b1;
        w_sval = '0;
        priority if ((w_ainf && w_fa != '0) || (w_binf && w_fb != '0) ||
                     (w_cinf && w_fc != '0)) begin
            w_sval = bmm_pkg::QNAN;
        end else if (w_ainf || w_binf) begin
            if (w_azero || w_bzero) w_sval = bmm_pkg::QNAN;
            else if (w_cinf && w_sc != w_sp) w_sval = bmm_pkg::QNAN;
            else w_sval = {w_sp, 31'h0} | bmm_pkg::PINF;
        end else if (w_cinf) begin
            w_sval = i_c;
        end else if (w_azero || w_bzero) begin
            w_sval = w_czero ? {w_sp & w_sc, 31'h0} : i_c;
        end else begin
            w_spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod  <= {(w_ea != '0), w_fa} * {(w_eb != '0), w_fb};
        r1_eab   <= {1'b0, (w_ea != '0) ? w_ea : 8'd1} + {1'b0, (w_eb != '0) ? w_eb : 8'd1};
        r1_cm    <= {(w_ec != '0), w_fc};
        r1_ce    <= (w_ec != '0) ? w_ec : 8'd1;
        r1_sp    <= w_sp;
        r1_sc    <= w_sc;
        r1_czero <= w_czero;
        r1_spec  <= w_spec;
        r1_sval  <= w_sval;
    end

    // stage 2: normalize both terms to bit 61
    logic [5:0]         w_s2x, w_s2y;
    logic [63:0]        r2_xm, r2_ym;
    logic signed [11:0] r2_xe, r2_ye;
    logic               r2_xs, r2_ys, r2_czero, r2_spec;
    logic [31:0]        r2_sval;

    assign w_s2x = 6'd61 - bmm_pkg::top_bit({16'h0, r1_prod});
    assign w_s2y = 6'd61 - bmm_pkg::top_bit({40'h0, r1_cm});

    always_ff @(posedge i_clk) begin
        r2_xm    <= {16'h0, r1_prod} << w_s2x;
        r2_ym    <= {40'h0, r1_cm} << w_s2y;
        r2_xe    <= $signed({3'b000, r1_eab}) - 12'sd300 - $signed({6'b0, w_s2x});
        r2_ye    <= $signed({4'b0000, r1_ce}) - 12'sd150 - $signed({6'b0, w_s2y});
        r2_xs    <= r1_sp;
        r2_ys    <= r1_sc;
        r2_czero <= r1_czero;
        r2_spec  <= r1_spec;
        r2_sval  <= r1_sval;
    end

    // stage 3: order by exponent, align the smaller with sticky
    logic               w_swap;
    logic [63:0]        w3_xm, w3_ym, w3_mask;
    logic signed [11:0] w3_xe, w3_ye, w3_d;
    logic               w3_xs, w3_ys;
    logic [63:0]        r3_xm, r3_ym;
    logic signed [11:0] r3_xe;
    logic               r3_xs, r3_ys, r3_czero, r3_spec;
    logic [31:0]        r3_sval;

    always_comb begin
        w_swap = !r2_czero && (r2_xe < r2_ye);
        w3_xm  = w_swap ? r2_ym : r2_xm;
        w3_ym  = w_swap ? r2_xm : r2_ym;
        w3_xe  = w_swap ? r2_ye : r2_xe;
        w3_ye  = w_swap ? r2_xe : r2_ye;
        w3_xs  = w_swap ? r2_ys : r2_xs;
        w3_ys  = w_swap ? r2_xs : r2_ys;
        w3_d   = w3_xe - w3_ye;
        w3_mask = (64'd1 << w3_d[5:0]) - 64'd1;
    end

    always_ff @(posedge i_clk) begin
        r3_xm <= w3_xm;
        if (w3_d >= 12'sd63) r3_ym <= 64'd1;
        else r3_ym <= (w3_ym >> w3_d[5:0]) | {63'h0, |(w3_ym & w3_mask)};
        r3_xe    <= w3_xe;
        r3_xs    <= w3_xs;
        r3_ys    <= w3_ys;
        r3_czero <= r2_czero;
        r3_spec  <= r2_spec;
        r3_sval  <= r2_sval;
    end

    // stage 4: add or subtract magnitudes
    logic [63:0]        w4_r;
    logic               w4_rs;
    logic [63:0]        r4_r;
    logic signed [11:0] r4_e;
    logic               r4_rs, r4_spec;
    logic [31:0]        r4_sval;

    always_comb begin
        priority if (r3_czero) begin
            w4_r  = r3_xm;
            w4_rs = r3_xs;
        end else if (r3_xs == r3_ys) begin
            w4_r  = r3_xm + r3_ym;
            w4_rs = r3_xs;
        end else if (r3_xm >= r3_ym) begin
            w4_r  = r3_xm - r3_ym;
            w4_rs = r3_xs;
        end else begin
            w4_r  = r3_ym - r3_xm;
            w4_rs = r3_ys;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_r  <= w4_r;
        r4_rs <= w4_rs;
        r4_e  <= r3_xe;
        // exact cancellation is +0
        r4_spec <= r3_spec || (w4_r == '0);
        r4_sval <= r3_spec ? r3_sval : 32'h0;
    end

    // stage 5: rounding position, clamped at the subnormal floor
    logic signed [11:0] w5_sh, w5_lim;
    logic [63:0]        r5_r;
    logic signed [11:0] r5_e, r5_sh;
    logic               r5_rs, r5_spec;
    logic [31:0]        r5_sval;

    always_comb begin
        w5_sh  = $signed({6'b0, bmm_pkg::top_bit(r4_r)}) - 12'sd23;
        w5_lim = -12'sd149 - r4_e;
        if (w5_sh < w5_lim) w5_sh = w5_lim;
    end

    always_ff @(posedge i_clk) begin
        r5_r    <= r4_r;
        r5_e    <= r4_e;
        r5_sh   <= w5_sh;
        r5_rs   <= r4_rs;
        r5_spec <= r4_spec;
        r5_sval <= r4_sval;
    end

    // stage 6: shift, round, pack
    logic [63:0]        w6_q, w6_rem, w6_half, w6_mask;
    logic signed [11:0] w6_qe, w6_neg, w6_be;
    logic [31:0]        w6_res;
    logic [31:0]        r6_res;

    always_comb begin
        w6_neg  = -r5_sh;
        w6_mask = (64'd1 << r5_sh[5:0]) - 64'd1;
        w6_rem  = r5_r & w6_mask;
        w6_half = 64'd1 << (r5_sh[5:0] - 6'd1);
        w6_q    = '0;
        if (r5_sh <= 12'sd0) begin
            w6_q = r5_r << w6_neg[5:0];
        end else if (r5_sh >= 12'sd64) begin
            w6_q = '0;
        end else begin
            w6_q = r5_r >> r5_sh[5:0];
            if (w6_rem > w6_half || (w6_rem == w6_half && w6_q[0])) w6_q = w6_q + 64'd1;
        end
        w6_qe = r5_e + r5_sh;
        if (w6_q >= 64'h100_0000) begin
            w6_q  = w6_q >> 1;
            w6_qe = w6_qe + 12'sd1;
        end
        w6_be = w6_qe + 12'sd150;
        priority if (w6_q == '0) w6_res = {r5_rs, 31'h0};
        else if (w6_q < 64'h80_0000) w6_res = {r5_rs, 8'h00, w6_q[22:0]};
        else if (w6_be >= 12'sd255) w6_res = {r5_rs, 31'h0} | bmm_pkg::PINF;
        else w6_res = {r5_rs, w6_be[7:0], w6_q[22:0]};
    end

    always_ff @(posedge i_clk) begin
        r6_res <= r5_spec ? r5_sval : w6_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else r_v <= {r_v[bmm_pkg::FMA_STAGES-2:0], i_start};
    end

    assign o_done   = r_v[bmm_pkg::FMA_STAGES-1];
    assign o_result = r6_res;

endmodule

>>> design/bmm_back.sv
// ----------------------------------------------------------------------------
// bmm_back
// Executes queued commands: element stores, and tile accumulation on one FMA.
// ----------------------------------------------------------------------------
module bmm_back #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  bmm_pkg::t_cmd             i_cmd,
    input  logic [bmm_pkg::CFG_W-1:0] i_k,
    output logic                      o_pop,
    output logic                      o_valid,
    output bmm_pkg::t_out_item        o_result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_READ  = 5'b00010,
        B_ISSUE = 5'b00100,
        B_MAC   = 5'b01000,
        B_EMIT  = 5'b10000
    } t_bstate;

    t_bstate                   r_state, n_state;
    logic [5:0]                r_r0, n_r0, r_c0, n_c0;
    logic [1:0]                r_i, n_i, r_j, n_j;
    logic [bmm_pkg::CFG_W-1:0] r_p, n_p;
    logic [31:0]               r_acc, n_acc;
    logic                      r_out_valid, n_out_valid;
    bmm_pkg::t_out_item        r_out, n_out;

    logic [31:0]   mem_a [DEPTH];
    logic [31:0]   mem_b [DEPTH];
    logic [31:0]   r_a_rd, r_b_rd;
    logic          w_we_a, w_we_b, w_re, w_last;
    logic [AW-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic          w_fma_done;
    logic [31:0]   w_fma_res;

    assign w_waddr   = AW'(32'(i_cmd.row) * 32'(MAX_DIM) + 32'(i_cmd.col));
    assign w_raddr_a = AW'((32'(r_r0) + 32'(r_i)) * 32'(MAX_DIM) + 32'(r_p));
    assign w_raddr_b = AW'(32'(r_p) * 32'(MAX_DIM) + 32'(r_c0) + 32'(r_j));
    assign w_last    = (r_i == 2'd3) && (r_j == 2'd3);

    always_comb begin
        n_state     = r_state;
        n_r0        = r_r0;
        n_c0        = r_c0;
        n_i         = r_i;
        n_j         = r_j;
        n_p         = r_p;
        n_acc       = r_acc;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_we_a      = 1'b0;
        w_we_b      = 1'b0;
        w_re        = 1'b0;
        o_pop       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        bmm_pkg::K_WR_A: w_we_a = 1'b1;
                        bmm_pkg::K_WR_B: w_we_b = 1'b1;
                        bmm_pkg::K_TILE: begin
                            n_r0    = i_cmd.row;
                            n_c0    = i_cmd.col;
                            n_i     = '0;
                            n_j     = '0;
                            n_p     = '0;
                            n_acc   = '0;
                            n_state = B_READ;
                        end
                        default: ;
                    endcase
                end
            end
            B_READ: begin
                w_re    = 1'b1;
                n_state = B_ISSUE;
            end
            B_ISSUE: n_state = B_MAC;
            B_MAC: begin
                if (w_fma_done) begin
                    n_acc = w_fma_res;
                    if (r_p == i_k - 7'd1) begin
                        n_state = B_EMIT;
                    end else begin
                        n_p     = r_p + 7'd1;
                        n_state = B_READ;
                    end
                end
            end
            B_EMIT: begin
                n_out_valid     = 1'b1;
                n_out.out_row   = r_r0 + {4'b0, r_i};
                n_out.out_col   = r_c0 + {4'b0, r_j};
                n_out.out_value = r_acc;
                n_out.last      = w_last;
                n_acc           = '0;
                n_p             = '0;
                n_j             = r_j + 2'd1;
                if (r_j == 2'd3) n_i = r_i + 2'd1;
                n_state         = w_last ? B_IDLE : B_READ;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0  <= n_r0;
        r_c0  <= n_c0;
        r_i   <= n_i;
        r_j   <= n_j;
        r_p   <= n_p;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we_a) mem_a[w_waddr] <= i_cmd.value;
        if (w_re) r_a_rd <= mem_a[w_raddr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) mem_b[w_waddr] <= i_cmd.value;
        if (w_re) r_b_rd <= mem_b[w_raddr_b];
    end

    bmm_fma u_fma (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == B_ISSUE),
        .i_a      (r_a_rd),
        .i_b      (r_b_rd),
        .i_c      (r_acc),
        .o_done   (w_fma_done),
        .o_result (w_fma_res)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // one FMA in flight: a result only comes back while waiting for it
    a_fma_done_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fma_done |-> r_state == B_MAC)
        else $error("fma result outside accumulate wait");

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == B_EMIT))
        else $error("result strobe without emit");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT && w_last) |=> (r_out_valid && r_out.last && r_state == B_IDLE))
        else $error("tile end not marked");

endmodule

>>> design/blocked_matrix_multiply_fp32_core.sv
// ----------------------------------------------------------------------------
// blocked_matrix_multiply_fp32_core
// fp32 matrix product C = A*B from element stores, one 4x4 tile of C per call.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry command
// queue sits between intake and execution, so busy rises only when it is
// full. Element writes are stored as they leave the queue. A tile leaves
// the queue, then runs one inner step at a time through a single six-stage
// FMA: each step reads both stores, issues to the FMA and waits for its
// result, so the FMA latency in the accumulate loop sets the pace; k, the
// effective inner size, gives the number of steps per C element. Tiles
// outside the matrix and action 3 produce nothing. Results appear for one
// cycle each on o_result with o_valid high and cannot be stalled; the
// sixteenth of a tile has last set. Stores are not cleared at reset.
// ----------------------------------------------------------------------------
module blocked_matrix_multiply_fp32_core #(
    parameter int MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bmm_pkg::t_in_item             i_item,
    input  logic                          i_cfg_we,
    input  logic [bmm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bmm_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_valid,
    output bmm_pkg::t_out_item            o_result
);

    logic                      w_cmd_valid, w_pop;
    bmm_pkg::t_cmd             w_cmd;
    logic [bmm_pkg::CFG_W-1:0] w_k;

    bmm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop       (w_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .o_k         (w_k)
    );

    bmm_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .i_k         (w_k),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

>>> dv/blocked_matrix_multiply_fp32_core_test.sv
// ----------------------------------------------------------------------------
// blocked_matrix_multiply_fp32_core_test
// Self-checking bench for the blocked fp32 matrix multiply core: element
// loads and tile requests go in through the command port, every C element
// coming out is checked against a bit-exact fused multiply-add predictor.
// ----------------------------------------------------------------------------
module blocked_matrix_multiply_fp32_core_test;
    import bmm_pkg::*;

    localparam int DIM       = 64;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in_item          i_item = '0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              o_valid;
    t_out_item         o_result;

    blocked_matrix_multiply_fp32_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // words waiting to be sent, C elements waiting to come out
    t_in_item    word_q[$];
    t_out_item   c_expect_q[$];

    // predictor copy of the stores and size registers
    logic [31:0] a_mirror[DIM*DIM];
    logic [31:0] b_mirror[DIM*DIM];
    logic [CFG_W-1:0] rows_reg = SIZE_RESET;
    logic [CFG_W-1:0] cols_reg = SIZE_RESET;
    logic [CFG_W-1:0] inner_reg = SIZE_RESET;

    // generator-side bookkeeping: which entries hold data
    bit          a_loaded[DIM*DIM];
    bit          b_loaded[DIM*DIM];
    int          gen_n, gen_m, gen_k;

    int          idle_pct = 0;
    logic        calm = 1'b0;
    int          err_cnt = 0;
    int          tiles_run = 0;
    int          elems_checked = 0;
    int          words_in = 0;
    int          wdog = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int msb64(longint unsigned v);
        int p;
        p = 0;
        while (v > 1) begin
            v >>= 1;
            p++;
        end
        return p;
    endfunction

    // round s * r * 2^e to binary32, nearest even
    function automatic logic [31:0] fp32_round(bit s, longint unsigned r, int e);
        int p, sh, qe;
        longint unsigned q, rem, half;
        p = msb64(r);
        sh = p - 23;
        if (sh < -149 - e) sh = -149 - e;
        if (sh <= 0) begin
            q = r << (-sh);
        end else if (sh >= 64) begin
            q = 0;
        end else begin
            rem = r & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q = r >> sh;
            if (rem > half || (rem == half && q[0])) q++;
        end
        qe = e + sh;
        if (q == 0) return {s, 31'd0};
        if (q >= (64'd1 << 24)) begin
            q >>= 1;
            qe++;
        end
        if (q < (64'd1 << 23)) return {s, q[30:0]};
        if (qe + 150 >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(qe + 150), q[22:0]};
    endfunction

    // a*b + c with one rounding
    function automatic logic [31:0] fp32_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        bit sa, sb, sc, sp, xs, ys, rs, tsg;
        int ea, eb, ec, xe, ye, sft, d, te;
        longint unsigned xm, ym, r, tm, sticky;
        bit a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
        sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
        ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
        a_inf = ea == 255; b_inf = eb == 255; c_inf = ec == 255;
        a_zero = a[30:0] == 0; b_zero = b[30:0] == 0; c_zero = c[30:0] == 0;
        if ((a_inf && a[22:0] != 0) || (b_inf && b[22:0] != 0) || (c_inf && c[22:0] != 0))
            return QNAN;
        if (a_inf || b_inf) begin
            if (a_zero || b_zero) return QNAN;
            if (c_inf && sc != sp) return QNAN;
            return {sp, PINF[30:0]};
        end
        if (c_inf) return c;
        if (a_zero || b_zero) begin
            if (c_zero) return {sp & sc, 31'd0};
            return c;
        end
        xm = longint'({ea != 0, a[22:0]}) * longint'({eb != 0, b[22:0]});
        sft = 61 - msb64(xm);
        xm <<= sft;
        xe = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 300 - sft;
        xs = sp;
        if (c_zero) return fp32_round(xs, xm, xe);
        ym = longint'({ec != 0, c[22:0]});
        sft = 61 - msb64(ym);
        ym <<= sft;
        ye = (ec != 0 ? ec : 1) - 150 - sft;
        ys = sc;
        if (xe < ye) begin
            tm = xm; te = xe; tsg = xs;
            xm = ym; xe = ye; xs = ys;
            ym = tm; ye = te; ys = tsg;
        end
        d = xe - ye;
        if (d >= 63) begin
            ym = 1;
        end else begin
            sticky = ((ym & ((64'd1 << d) - 64'd1)) != 0) ? 64'd1 : 64'd0;
            ym = (ym >> d) | sticky;
        end
        if (xs == ys) begin
            r = xm + ym; rs = xs;
        end else if (xm >= ym) begin
            r = xm - ym; rs = xs;
        end else begin
            r = ym - xm; rs = ys;
        end
        if (r == 0) return 32'd0;
        return fp32_round(rs, r, xe);
    endfunction

    function automatic int eff_dim(logic [CFG_W-1:0] raw);
        int v;
        v = raw & 7'h7C;
        if (v < TILE) v = TILE;
        if (v > (DIM & ~3)) v = DIM & ~3;
        return v;
    endfunction

    // predictor: apply one accepted word, queue the C elements it yields
    task automatic tile_product(t_in_item w);
        int n, m, k, r0, c0;
        logic [31:0] acc;
        t_out_item e;
        case (w.action)
            ACT_WR_A: a_mirror[w.row * DIM + w.col] = w.value;
            ACT_WR_B: b_mirror[w.row * DIM + w.col] = w.value;
            ACT_TILE: begin
                n = eff_dim(rows_reg);
                m = eff_dim(cols_reg);
                k = eff_dim(inner_reg);
                r0 = w.row & ~3;
                c0 = w.col & ~3;
                if (r0 < n && c0 < m) begin
                    tiles_run++;
                    for (int i = 0; i < TILE; i++) begin
                        for (int j = 0; j < TILE; j++) begin
                            acc = 32'd0;
                            for (int p = 0; p < k; p++)
                                acc = fp32_fma(a_mirror[(r0 + i) * DIM + p],
                                               b_mirror[p * DIM + c0 + j], acc);
                            e.out_row = 6'(r0 + i);
                            e.out_col = 6'(c0 + j);
                            e.out_value = acc;
                            e.last = (i == TILE - 1) && (j == TILE - 1);
                            c_expect_q.push_back(e);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            calm <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW_COUNT:  rows_reg <= i_cfg_wdata;
                    REG_COL_COUNT:  cols_reg <= i_cfg_wdata;
                    REG_INNER_SIZE: inner_reg <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                tile_product(i_item);
                words_in++;
            end
            if ($urandom_range(99) < 2) calm <= !calm;
            if (!start || !busy) begin
                if (word_q.size() > 0 && (calm || $urandom_range(99) >= idle_pct)) begin
                    start <= 1'b1;
                    i_item <= word_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) wdog <= 0;
            else wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("timeout: no word moved for %0d cycles", WDOG_MAX);
                $display("CHECKS FAILED");
                $finish;
            end
            if (o_valid) begin
                if (c_expect_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected C word: row %0d col %0d val %h last %b",
                                 o_result.out_row, o_result.out_col,
                                 o_result.out_value, o_result.last);
                    err_cnt++;
                end else begin
                    want = c_expect_q.pop_front();
                    elems_checked++;
                    if (o_result !== want) begin
                        if (err_cnt < 10)
                            $display("C mismatch: exp r%0d c%0d %h l%b, got r%0d c%0d %h l%b",
                                     want.out_row, want.out_col, want.out_value, want.last,
                                     o_result.out_row, o_result.out_col,
                                     o_result.out_value, o_result.last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    function automatic logic [31:0] rand_fp32();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4) return {1'($urandom), 31'd0};
        if (sel < 7) return {1'($urandom), 8'hFF, 23'd0};
        if (sel < 9) return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
        if (sel < 14) return {1'($urandom), 8'h00, 23'($urandom)};
        if (sel < 16) return {1'($urandom), 8'hFE, 23'($urandom)};
        if (sel < 80) return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        return $urandom;
    endfunction

    task automatic push_word(logic [1:0] act, int row, int col, logic [31:0] val);
        t_in_item w;
        w.action = act;
        w.row = 6'(row);
        w.col = 6'(col);
        w.value = val;
        if (act == ACT_WR_A) a_loaded[w.row * DIM + w.col] = 1'b1;
        if (act == ACT_WR_B) b_loaded[w.row * DIM + w.col] = 1'b1;
        word_q.push_back(w);
    endtask

    // tile request; for a tile inside the matrix, loads any operand not yet written first
    task automatic push_tile(int row, int col);
        int r0, c0;
        r0 = row & ~3;
        c0 = col & ~3;
        if (r0 < gen_n && c0 < gen_m) begin
            for (int i = 0; i < TILE; i++)
                for (int p = 0; p < gen_k; p++)
                    if (!a_loaded[(r0 + i) * DIM + p]) push_word(ACT_WR_A, r0 + i, p, rand_fp32());
            for (int p = 0; p < gen_k; p++)
                for (int j = 0; j < TILE; j++)
                    if (!b_loaded[p * DIM + c0 + j]) push_word(ACT_WR_B, p, c0 + j, rand_fp32());
        end
        push_word(ACT_TILE, row, col, $urandom);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_dims(int n, int m, int k);
        write_reg(REG_ROW_COUNT, 7'(n));
        write_reg(REG_COL_COUNT, 7'(m));
        write_reg(REG_INNER_SIZE, 7'(k));
        gen_n = eff_dim(7'(n));
        gen_m = eff_dim(7'(m));
        gen_k = eff_dim(7'(k));
    endtask

    // wait for all words sent and all C elements out, then let loads settle
    task automatic drain();
        do @(negedge i_clk);
        while (word_q.size() != 0 || start || c_expect_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic gen_random(int count, int tile_pct);
        int sel, r, c, mode;
        repeat (count) begin
            sel = $urandom_range(99);
            mode = $urandom_range(9);
            if (sel < 5) begin
                word_q.push_back(t_in_item'{2'd3, 6'($urandom), 6'($urandom), 32'($urandom)});
            end else if (sel < 5 + tile_pct) begin
                if (mode < 7) begin
                    r = $urandom_range(gen_n - 1) & ~3;
                    c = $urandom_range(gen_m - 1) & ~3;
                end else if (mode < 9) begin
                    r = $urandom_range(gen_n - 1);
                    c = $urandom_range(gen_m - 1);
                end else begin
                    r = $urandom_range(63);
                    c = $urandom_range(63);
                end
                push_tile(r, c);
            end else if (sel & 1) begin
                if (mode < 2) push_word(ACT_WR_A, $urandom_range(63), $urandom_range(63), $urandom);
                else push_word(ACT_WR_A, $urandom_range(gen_n - 1), $urandom_range(gen_k - 1),
                               rand_fp32());
            end else begin
                if (mode < 2) push_word(ACT_WR_B, $urandom_range(63), $urandom_range(63), $urandom);
                else push_word(ACT_WR_B, $urandom_range(gen_k - 1), $urandom_range(gen_m - 1),
                               rand_fp32());
            end
        end
    endtask

    initial begin
        int ph_n[3]  = '{8, 127, 5};
        int ph_m[3]  = '{8, 3, 126};
        int ph_k[3]  = '{8, 4, 6};
        int ph_cnt[3] = '{25, 35, 35};
        int ph_tile[3] = '{25, 15, 15};
        int ph_idle[3] = '{0, 55, 30};
        foreach (a_mirror[i]) begin
            a_mirror[i] = '0;
            b_mirror[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: special operands, alignment and range cases
        set_dims(0, 0, 0);
        push_word(ACT_WR_A, 0, 0, PINF);
        push_word(ACT_WR_B, 0, 0, 32'h0000_0000);
        push_word(ACT_WR_A, 0, 1, 32'hFF80_0000);
        push_word(ACT_WR_A, 0, 2, 32'h7FC1_2345);
        push_word(ACT_WR_A, 1, 0, 32'h3F80_0000);
        push_word(ACT_WR_B, 0, 1, 32'h3F80_0000);
        push_word(ACT_WR_A, 1, 1, 32'h3F80_0000);
        push_word(ACT_WR_B, 1, 1, 32'hBF80_0000);
        push_word(ACT_WR_A, 1, 2, 32'h0000_0000);
        push_word(ACT_WR_A, 1, 3, 32'h8000_0000);
        push_word(ACT_WR_A, 2, 0, 32'h7F7F_FFFF);
        push_word(ACT_WR_B, 0, 2, 32'h7F7F_FFFF);
        push_word(ACT_WR_A, 3, 0, 32'h0000_0001);
        push_word(ACT_WR_B, 0, 3, 32'h3F00_0000);
        for (int p = 1; p < 4; p++) begin
            push_word(ACT_WR_A, 2, p, 32'h0);
            push_word(ACT_WR_A, 3, p, 32'h0);
        end
        push_word(ACT_WR_A, 63, 63, 32'hFFFF_FFFF);
        push_word(ACT_WR_B, 63, 63, 32'hFFFF_FFFF);
        push_tile(0, 0);
        push_tile(2, 3);
        push_tile(4, 0);
        push_tile(0, 4);
        push_tile(63, 63);
        word_q.push_back(t_in_item'{2'd3, 6'd0, 6'd0, 32'd0});
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            set_dims(ph_n[ph], ph_m[ph], ph_k[ph]);
            idle_pct = ph_idle[ph];
            gen_random(ph_cnt[ph], ph_tile[ph]);
            drain();
        end

        $display("run covered %0d words in, %0d tiles computed, %0d C elements checked",
                 words_in, tiles_run, elems_checked);
        $display("row/col sizes 4 to 64 incl. masking and clamping, inner 4 to 8, %s",
                 "sender idling 0/30/55 pct");
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> blocked_matrix_multiply_fp32_core.f
design/bmm_pkg.sv
design/bmm_front.sv
design/bmm_fma.sv
design/bmm_back.sv
design/blocked_matrix_multiply_fp32_core.sv
dv/blocked_matrix_multiply_fp32_core_test.sv
